// File: hw/rtl/tvps_pkg.sv
// Shared types for the trapezoid velocity point stepper.
// Holds the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tvps_pkg;

	// Commands from the controller, one strobe per datapath operation.
	typedef struct packed {
		logic load;      // capture the accepted input item
		logic prep;      // magnitudes, major axis and braking distance
		logic speed;     // update the speed register
		logic mul;       // speed times minor magnitude
		logic num;       // form the rounded numerator, start the divider
		logic div_step;  // one quotient bit
		logic out_load;  // write the result into the output register
	} tvps_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic div_last;  // the current divider step is the final one
	} tvps_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/trapezoid_velocity_point_stepper_unit.sv
// Top level of the trapezoid velocity point stepper.
// Joins tvps_ctrl and tvps_dp; uses tvps_pkg.
//
// Channel   Direction  Handshake            Fields
// input     in         in_valid / in_stall  actual_x, actual_y, target_x, target_y
// output    out        out_valid / out_stall next_x, next_y
//
// A result reaches the output register after its item passes the prep, speed, multiply
// and numerator states and the bit-serial divider that forms the minor-axis step, one
// quotient bit a cycle. The next item can be accepted in the cycle after the result is
// loaded.
// One item is worked on at a time; the next is accepted once the result sits in the
// output register, even while that result is still stalled.
// Reset clears the speed to zero and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_velocity_point_stepper_unit #(
	parameter int COORD_WIDTH = 16,
	parameter int SPEED_WIDTH = 9
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  signed [COORD_WIDTH-1:0] actual_x,
	input  wire  signed [COORD_WIDTH-1:0] actual_y,
	input  wire  signed [COORD_WIDTH-1:0] target_x,
	input  wire  signed [COORD_WIDTH-1:0] target_y,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic signed [COORD_WIDTH-1:0] next_x,
	output logic signed [COORD_WIDTH-1:0] next_y
);
	import tvps_pkg::*;

	tvps_cmd_t  cmd;
	tvps_stat_t stat;

	// Sequencer.
	tvps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Arithmetic and state.
	tvps_dp #(
		.CW (COORD_WIDTH),
		.SW (SPEED_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.actual_x (actual_x),
		.actual_y (actual_y),
		.target_x (target_x),
		.target_y (target_y),
		.next_x   (next_x),
		.next_y   (next_y)
	);

	// An accepted item keeps the input stalled while it is worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting an item");

	// A new result only appears at the end of a busy period.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> in_stall && !$past(cmd.load))
		else $error("result loaded without a finished item");

	// The divider stops after its final step.
	a_divider_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && stat.div_last |=> !cmd.div_step)
		else $error("divider kept stepping past its last bit");

endmodule

`default_nettype wire

// File: hw/rtl/tvps_ctrl.sv
// Controller state machine for the trapezoid velocity point stepper.
// Sequences the datapath and runs both handshakes; uses tvps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tvps_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire                    out_stall,
	output tvps_pkg::tvps_cmd_t    cmd,
	input  wire tvps_pkg::tvps_stat_t stat
);
	import tvps_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_SPEED = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_NUM   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new item when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SPEED;
			end
			ST_SPEED: begin
				cmd.speed = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_NUM;
			end
			ST_NUM: begin
				cmd.num = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tvps_dp.sv
// Datapath for the trapezoid velocity point stepper: speed register,
// braking distance multiplier, minor-axis restoring divider, output register.
// Uses tvps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tvps_dp #(
	parameter int CW = 16,
	parameter int SW = 9
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire tvps_pkg::tvps_cmd_t cmd,
	output tvps_pkg::tvps_stat_t   stat,
	input  wire  signed [CW-1:0]   actual_x,
	input  wire  signed [CW-1:0]   actual_y,
	input  wire  signed [CW-1:0]   target_x,
	input  wire  signed [CW-1:0]   target_y,
	output logic signed [CW-1:0]   next_x,
	output logic signed [CW-1:0]   next_y
);
	import tvps_pkg::*;

	localparam int DW   = CW + 1;
	localparam int NW   = SW + CW + 1;
	localparam int CMPW = ((2 * SW > DW) ? 2 * SW : DW) + 1;
	localparam int CNTW = $clog2(SW);
	localparam int XW   = SW + CW;

	// Captured item.
	logic [CW-1:0] ax_q, ay_q;
	logic [DW-1:0] dx_q, dy_q;

	// Prepared quantities.
	logic [DW-1:0]   amaj_q, amin_q;
	logic            ymaj_q, maj_neg_q, min_neg_q, zero_q;
	logic [CMPW-1:0] hold_q;

	// Speed state, product, divider.
	logic [SW-1:0]   speed_q;
	logic [NW-1:0]   prod_q;
	logic [DW-1:0]   rem_q;
	logic [SW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;

	logic [CW-1:0] next_x_q, next_y_q;

	// Combinational helpers.
	logic [DW-1:0]   adx, ady;
	logic            ymaj;
	logic [SW:0]     v_inc;
	logic [2*SW:0]   vv;
	logic [CMPW-1:0] rise, major_dist;
	logic [NW-1:0]   half, num;
	logic [DW:0]     trial;
	logic            ge;
	logic [XW-1:0]   v_ext, q_ext;
	logic [CW-1:0]   vc, qc, amaj_c, amin_c, nmaj, nmin;

	// Absolute deltas and major axis choice; y wins a tie.
	assign adx  = dx_q[DW-1] ? (~dx_q) + DW'(1) : dx_q;
	assign ady  = dy_q[DW-1] ? (~dy_q) + DW'(1) : dy_q;
	assign ymaj = !(adx > ady);

	// Braking distance v(v+1)/2 and the rise threshold (v+1)(v+2)/2.
	assign v_inc      = {1'b0, speed_q} + (SW+1)'(1);
	assign vv         = (2*SW+1)'(speed_q) * (2*SW+1)'(v_inc);
	assign major_dist = CMPW'(amaj_q);
	assign rise       = hold_q + CMPW'(speed_q) + CMPW'(1);

	// Rounded numerator: v*|dmin| plus or minus half of |dmaj|.
	assign half = NW'(amaj_q[DW-1:1]);
	always_comb begin
		if (!min_neg_q) begin
			num = prod_q + half;
		end else if (prod_q >= half) begin
			num = prod_q - half;
		end else begin
			num = half - prod_q;
		end
	end

	// One restoring divide step.
	assign trial = {rem_q, quo_q[SW-1]} - {1'b0, amaj_q};
	assign ge    = !trial[DW];
	assign stat.div_last = (cnt_q == CNTW'(SW - 1));

	// Step sizes cut to coordinate width, coordinates wrap.
	assign v_ext  = XW'(speed_q);
	assign q_ext  = XW'(quo_q);
	assign vc     = v_ext[CW-1:0];
	assign qc     = q_ext[CW-1:0];
	assign amaj_c = ymaj_q ? ay_q : ax_q;
	assign amin_c = ymaj_q ? ax_q : ay_q;
	assign nmaj   = maj_neg_q ? amaj_c - vc : amaj_c + vc;
	assign nmin   = min_neg_q ? amin_c - qc : amin_c + qc;

	// Speed register follows the trapezoid with saturation at both ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
		end else if (cmd.speed) begin
			if (major_dist >= rise) begin
				if (speed_q != '1) begin
					speed_q <= speed_q + SW'(1);
				end
			end else if (major_dist < hold_q) begin
				if (speed_q != '0) begin
					speed_q <= speed_q - SW'(1);
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= actual_x;
			ay_q <= actual_y;
			dx_q <= {target_x[CW-1], target_x} - {actual_x[CW-1], actual_x};
			dy_q <= {target_y[CW-1], target_y} - {actual_y[CW-1], actual_y};
		end
		if (cmd.prep) begin
			ymaj_q    <= ymaj;
			amaj_q    <= ymaj ? ady : adx;
			amin_q    <= ymaj ? adx : ady;
			maj_neg_q <= ymaj ? dy_q[DW-1] : dx_q[DW-1];
			min_neg_q <= ymaj ? dx_q[DW-1] : dy_q[DW-1];
			zero_q    <= (adx == '0) && (ady == '0);
			hold_q    <= CMPW'(vv[2*SW:1]);
		end
		if (cmd.mul) begin
			prod_q <= NW'(speed_q) * NW'(amin_q);
		end
		// The quotient never exceeds the speed, so the top bits start as remainder.
		if (cmd.num) begin
			rem_q <= num[NW-1:SW];
			quo_q <= num[SW-1:0];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[DW-1:0] : {rem_q[DW-2:0], quo_q[SW-1]};
			quo_q <= {quo_q[SW-2:0], ge};
			cnt_q <= cnt_q + CNTW'(1);
		end
		if (cmd.out_load) begin
			if (zero_q) begin
				next_x_q <= ax_q;
				next_y_q <= ay_q;
			end else if (ymaj_q) begin
				next_x_q <= nmin;
				next_y_q <= nmaj;
			end else begin
				next_x_q <= nmaj;
				next_y_q <= nmin;
			end
		end
	end

	assign next_x = next_x_q;
	assign next_y = next_y_q;

endmodule

`default_nettype wire

// File: verif/trapezoid_velocity_point_stepper_unit_tb.sv
// Self-checking testbench for trapezoid_velocity_point_stepper_unit.
// Walks a table of directed steps and then runs random motion chains. Each result is checked
// against an in-bench model of the speed profile. Needs the top-level RTL with tvps_ctrl, tvps_dp and tvps_pkg.
`timescale 1ns / 1ps

module trapezoid_velocity_point_stepper_unit_tb;

	localparam int COORD_W = 16;
	localparam int SPEED_W = 9;
	localparam int RAND_ITEMS = 1330;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX = 10;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam longint SPEED_TOP = (64'd1 << SPEED_W) - 1;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// One directed step; the expected point is used only when fixed is set.
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t tx;
		coord_t ty;
		logic   fixed;
		coord_t ex;
		coord_t ey;
	} step_row_t;

	localparam int DIR_ROWS = 23;
	localparam step_row_t DIR_TABLE [DIR_ROWS] = '{
		'{0, 0, 0, 0, 1'b1, 0, 0},                      // standing still at reset
		'{100, 200, 100, 200, 1'b1, 100, 200},          // already on target
		'{0, 0, 10, 0, 1'b1, 1, 0},                     // start moving, no minor delta
		'{1, 0, 10, 0, 1'b1, 3, 0},                     // accelerate
		'{3, 0, 3, -20, 1'b1, 3, -3},                   // y major, negative direction
		'{0, 0, 7, 7, 1'b1, 3, 3},                      // tie goes to y, speed holds
		'{-32768, -32768, 32767, 32767, 1'b1, -32764, -32764}, // full-range diagonal
		'{32767, 32767, -32768, -32768, 1'b0, 0, 0},
		'{32767, -32768, -32768, 32767, 1'b0, 0, 0},
		'{-32768, 32767, 32767, -32768, 1'b0, 0, 0},
		'{-32768, 0, 32767, 1, 1'b0, 0, 0},
		'{0, -32768, -1, 32767, 1'b0, 0, 0},
		'{0, 0, -100, 37, 1'b0, 0, 0},                  // minor rounding, all sign mixes
		'{0, 0, 100, -37, 1'b0, 0, 0},
		'{0, 0, 37, -100, 1'b0, 0, 0},
		'{0, 0, -37, 100, 1'b0, 0, 0},
		'{0, 0, -1, 1, 1'b0, 0, 0},                     // overshoot on a tie
		'{32766, 0, 32767, 0, 1'b0, 0, 0},              // overshoot wraps past the top
		'{0, -32767, 0, -32768, 1'b0, 0, 0},            // overshoot wraps past the bottom
		'{5, 5, 5, 5, 1'b0, 0, 0},                      // on target while still moving
		'{-3, 9, -3, 9, 1'b0, 0, 0},
		'{0, 0, 3, -1, 1'b0, 0, 0},
		'{0, 0, -1, 0, 1'b0, 0, 0}
	};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t actual_x = '0;
	coord_t actual_y = '0;
	coord_t target_x = '0;
	coord_t target_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t next_x;
	coord_t next_y;

	trapezoid_velocity_point_stepper_unit #(
		.COORD_WIDTH(COORD_W),
		.SPEED_WIDTH(SPEED_W)
	) dut (.*);

	// Model state and bookkeeping.
	logic [SPEED_W-1:0] model_speed = '0;
	int                 peak_speed = 0;
	int                 overshoots = 0;
	point_t             pending_points [$];
	int                 mismatches = 0;
	int                 cycles = 0;
	int                 burst_left = 0;
	coord_t             last_x = '0;
	coord_t             last_y = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Minor-axis displacement toward the target, rounded and truncated toward zero.
	function automatic longint minor_shift(input longint major_step, input longint d_minor,
			input longint d_major);
		longint m;
		if (d_minor == 0 || d_major == 0)
			return 0;
		m = (major_step * d_minor + d_major / 2) / d_major;
		if (m < 0)
			m = -m;
		return d_minor > 0 ? m : -m;
	endfunction

	// Advances the speed profile by one step and returns the next point.
	function automatic point_t advance_point(input coord_t ax, input coord_t ay,
			input coord_t tx, input coord_t ty);
		longint dx, dy, adx, ady, major_dist, v, hold_dist, rise_dist, s, nx, ny;
		point_t p;
		dx = longint'(tx) - longint'(ax);
		dy = longint'(ty) - longint'(ay);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		major_dist = adx > ady ? adx : ady;
		v = longint'(model_speed);
		hold_dist = v * (v + 1) / 2;
		rise_dist = hold_dist + v + 1;
		if (major_dist >= rise_dist) begin
			if (v < SPEED_TOP)
				v++;
		end else if (major_dist < hold_dist) begin
			if (v > 0)
				v--;
		end
		model_speed = v[SPEED_W-1:0];
		if (v > peak_speed)
			peak_speed = int'(v);
		if (major_dist != 0 && v > major_dist)
			overshoots++;
		nx = ax;
		ny = ay;
		if (adx > ady) begin
			s = dx > 0 ? v : -v;
			nx = ax + s;
			ny = ay + minor_shift(s, dy, dx);
		end else if (ady != 0) begin
			s = dy > 0 ? v : -v;
			ny = ay + s;
			nx = ax + minor_shift(s, dx, dy);
		end
		p.x = nx[COORD_W-1:0];
		p.y = ny[COORD_W-1:0];
		return p;
	endfunction

	// Mostly uniform, with weight on the range ends and on small values near zero.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3: return coord_t'(int'($urandom_range(0, 200)) - 100);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Sends one item in bursts with random gaps and records what it should produce.
	task automatic send_item(input coord_t ax, input coord_t ay, input coord_t tx,
			input coord_t ty, input logic fixed, input coord_t ex, input coord_t ey);
		int gap;
		point_t p;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		actual_x <= ax;
		actual_y <= ay;
		target_x <= tx;
		target_y <= ty;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		p = advance_point(ax, ay, tx, ty);
		last_x = p.x;
		last_y = p.y;
		if (fixed) begin
			p.x = ex;
			p.y = ey;
		end
		pending_points.push_back(p);
	endtask

	// Receiver stalls in runs of changing character: free, light, heavy and solid.
	int stall_mode = 0;
	int stall_run = 0;
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = $urandom_range(10, 80);
		end
		stall_run--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= 1'b1;
		endcase
	end

	// Check each accepted result against the oldest expected point.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result x=%0d y=%0d", next_x, next_y);
			end else begin
				want = pending_points.pop_front();
				if (next_x !== want.x || next_y !== want.y) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							want.x, want.y, next_x, next_y);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_points.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus: directed table, then random chains and noise, then drain.
	initial begin
		int rand_sent;
		int chain_len;
		coord_t cx, cy, gx, gy, ax, ay;
		rand_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(DIR_TABLE[i].ax, DIR_TABLE[i].ay, DIR_TABLE[i].tx, DIR_TABLE[i].ty,
				DIR_TABLE[i].fixed, DIR_TABLE[i].ex, DIR_TABLE[i].ey);

		while (rand_sent < RAND_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				// A chain follows its own results, so the speed builds and brakes.
				chain_len = $urandom_range(5, 200);
				if ($urandom_range(0, 1) == 0) begin
					cx = pick_coord();
					cy = pick_coord();
				end else begin
					cx = last_x;
					cy = last_y;
				end
				gx = pick_coord();
				gy = pick_coord();
				for (int k = 0; k < chain_len && rand_sent < RAND_ITEMS; k++) begin
					case ($urandom_range(0, 19))
						0: begin
							gx = pick_coord();
							gy = pick_coord();
						end
						1: begin
							gx = cx + coord_t'(int'($urandom_range(0, 64)) - 32);
							gy = cy + coord_t'(int'($urandom_range(0, 64)) - 32);
						end
						default: ;
					endcase
					send_item(cx, cy, gx, gy, 1'b0, '0, '0);
					cx = last_x;
					cy = last_y;
					rand_sent++;
				end
			end else begin
				// Unrelated single steps, some of them already on target.
				ax = pick_coord();
				ay = pick_coord();
				if ($urandom_range(0, 4) == 0)
					send_item(ax, ay, ax, ay, 1'b0, '0, '0);
				else
					send_item(ax, ay, pick_coord(), pick_coord(), 1'b0, '0, '0);
				rand_sent++;
			end
		end
		in_valid <= 1'b0;

		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		mismatches += pending_points.size();
		$display("Ran %0d directed and %0d random steps in %0d cycles.", DIR_ROWS, rand_sent,
			cycles);
		$display("Peak speed %0d, %0d overshooting steps, %0d mismatches.", peak_speed,
			overshoots, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
